/* design/ttt_pkg.sv */
// package of types, codes and a helper function for the traffic target table
`default_nettype none

package ttt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;

    // field widths
    localparam int ADDR_W    = 24;
    localparam int TIME_W    = 32;
    localparam int PAYLOAD_W = 64;
    localparam int EXPIRY_W  = 16;
    localparam int KIND_W    = 2;
    localparam int RSLOT_W   = 3;
    localparam int ACT_W     = 3;
    localparam int OSLOT_W   = 3;
    localparam int OCNT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // number of block-list registers
    localparam int BLOCK_REGS = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWEEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_UPDATED  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERTED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BLOCKED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OWN      = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ZERO     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_OTHER    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRY    = 3'd4;

    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd10;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ADDR_W-1:0]    addr;
        logic [TIME_W-1:0]    stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    // signed age now - stamp compared against the limit
    function automatic logic is_expired(
        input logic [TIME_W-1:0]   now,
        input logic [TIME_W-1:0]   stamp,
        input logic [EXPIRY_W-1:0] limit
    );
        logic [TIME_W:0] diff;
        diff = {1'b0, now} - {1'b0, stamp};
        return !diff[TIME_W] && (diff[TIME_W-1:0] > TIME_W'(limit));
    endfunction

endpackage

`default_nettype wire

/* design/ttt_if.sv */
// channel interfaces of the traffic target table
`default_nettype none

// input item channel
interface ttt_in_if
    import ttt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    target_address;
    logic [TIME_W-1:0]    report_time;
    logic [PAYLOAD_W-1:0] report_payload;
    logic [TIME_W-1:0]    now_seconds;
    logic [RSLOT_W-1:0]   read_slot;

    modport source (
        output valid, kind, target_address, report_time, report_payload,
               now_seconds, read_slot,
        input  ready
    );
    modport sink (
        input  valid, kind, target_address, report_time, report_payload,
               now_seconds, read_slot,
        output ready
    );
endinterface

// result channel
interface ttt_out_if
    import ttt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [OSLOT_W-1:0]   slot_used;
    logic [ADDR_W-1:0]    entry_address;
    logic [TIME_W-1:0]    entry_time;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [OCNT_W-1:0]    occupied_count;

    modport source (
        output valid, action, slot_used, entry_address, entry_time,
               entry_payload, occupied_count,
        input  ready
    );
    modport sink (
        input  valid, action, slot_used, entry_address, entry_time,
               entry_payload, occupied_count,
        output ready
    );
endinterface

// configuration write channel
interface ttt_cfg_if
    import ttt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/traffic_target_table.sv */
// traffic target table: tracked targets keyed by address, held in one memory
//
// channels: i_in takes items (report, sweep, read), o_out gives one result per
// item, i_cfg writes the block-list, own-address and expiry registers.
// a transaction completes on a rising edge with valid and ready high.
// the entries live in a synchronous memory with registered read data; the
// occupancy of each slot is a flip-flop, so an empty slot reads as zero.
// report and sweep items walk all TABLE_DEPTH slots through the single read
// port, read in order and checked as the data returns; ST_FIN then loads
// the result and the block returns to idle for the next item. a read item
// reads one slot; a rejected report or unused kind goes straight to ST_FIN.
// one item is worked on at a time; i_in.ready is high while the block is idle.
// the result sits in an output register, so the next item may start while it
// waits; a finished item holds in its final step while an older result waits unaccepted.
// i_cfg is always ready; write it only while the block is idle.
// reset (synchronous, active low) empties every slot and loads register
// defaults; no clearing pass is needed, the memory itself is not reset.
`default_nettype none

module traffic_target_table
    import ttt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    ttt_in_if.sink      i_in,
    ttt_out_if.source   o_out,
    ttt_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // configuration registers
    logic [ADDR_W-1:0]   r_blocked [BLOCK_REGS];
    logic [ADDR_W-1:0]   r_own;
    logic [EXPIRY_W-1:0] r_expiry;

    // entry memory and its read data
    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd_data;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_idx;
    t_entry              wr_ent;

    // control and item registers
    t_state              r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_used, n_used;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                r_store, n_store;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [TIME_W-1:0]   r_rtime, n_rtime;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [ACT_W-1:0]    r_act, n_act;
    logic [OSLOT_W-1:0]  r_slot, n_slot;
    t_entry              r_ent, n_ent;
    logic                r_rd_ok, n_rd_ok;

    // scan bookkeeping
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_cmp_valid, n_cmp_valid;
    logic [SLOT_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic                r_match_hit, n_match_hit;
    logic [SLOT_W-1:0]   r_match_idx, n_match_idx;
    logic [SLOT_W-1:0]   r_best_idx, n_best_idx;
    logic [TIME_W-1:0]   r_tmin, n_tmin;
    logic                r_stop, n_stop;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [ACT_W-1:0]    r_o_action, n_o_action;
    logic [OSLOT_W-1:0]  r_o_slot, n_o_slot;
    t_entry              r_o_ent, n_o_ent;
    logic [OCNT_W-1:0]   r_o_count, n_o_count;

    // helpers
    t_entry              beat_ent;
    logic                beat_exp;
    logic                issue_now;
    logic                free_any;
    logic [SLOT_W-1:0]   free_idx;
    logic [CNT_W-1:0]    used_cnt;
    logic                in_acc;
    logic                fin_go;
    logic [TIME_W-1:0]   in_rtime;

    // block-list match, zero never matches
    function automatic logic addr_blocked(
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] b0,
        input logic [ADDR_W-1:0] b1,
        input logic [ADDR_W-1:0] b2
    );
        return (a != '0) && (((b0 != '0) && (b0 == a)) ||
                             ((b1 != '0) && (b1 == a)) ||
                             ((b2 != '0) && (b2 == a)));
    endfunction

    assign in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign fin_go    = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);
    assign in_rtime  = (i_in.report_time == '0) ? i_in.now_seconds : i_in.report_time;
    assign issue_now = (r_state == ST_SCAN) && (r_issue < CNT_W'(TABLE_DEPTH));

    // memory data of the current beat, empty slots read as zero
    assign beat_ent = r_used[r_cmp_idx] ? r_rd_data : '0;
    assign beat_exp = is_expired(r_now, beat_ent.stamp, r_expiry);

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_kind      = r_kind;
        n_store     = r_store;
        n_addr      = r_addr;
        n_rtime     = r_rtime;
        n_payload   = r_payload;
        n_now       = r_now;
        n_act       = r_act;
        n_slot      = r_slot;
        n_ent       = r_ent;
        n_rd_ok     = r_rd_ok;
        n_issue     = r_issue;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_match_hit = r_match_hit;
        n_match_idx = r_match_idx;
        n_best_idx  = r_best_idx;
        n_tmin      = r_tmin;
        n_stop      = r_stop;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_action  = r_o_action;
        n_o_slot    = r_o_slot;
        n_o_ent     = r_o_ent;
        n_o_count   = r_o_count;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_ent      = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_kind      = i_in.kind;
                    n_addr      = i_in.target_address;
                    n_rtime     = in_rtime;
                    n_payload   = i_in.report_payload;
                    n_now       = i_in.now_seconds;
                    n_store     = 1'b0;
                    n_slot      = '0;
                    n_ent       = '0;
                    n_act       = ACT_OTHER;
                    n_issue     = '0;
                    n_match_hit = 1'b0;
                    n_stop      = 1'b0;
                    n_state     = ST_FIN;
                    case (i_in.kind)
                        KIND_REPORT: begin
                            if (addr_blocked(i_in.target_address, r_blocked[0],
                                             r_blocked[1], r_blocked[2])) begin
                                n_act = ACT_BLOCKED;
                            end else if (i_in.target_address == r_own) begin
                                n_act = ACT_OWN;
                            end else if (i_in.target_address == '0) begin
                                n_act = ACT_ZERO;
                            end else begin
                                n_store = 1'b1;
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_SWEEP: begin
                            n_state = ST_SCAN;
                        end
                        KIND_READ: begin
                            // single read issued right away, no further issues
                            rd_en       = 1'b1;
                            rd_addr     = SLOT_W'(i_in.read_slot);
                            n_cmp_valid = 1'b1;
                            n_cmp_idx   = SLOT_W'(i_in.read_slot);
                            n_issue     = CNT_W'(TABLE_DEPTH);
                            n_slot      = OSLOT_W'(i_in.read_slot);
                            n_rd_ok     = (32'(i_in.read_slot) < 32'(TABLE_DEPTH));
                            n_state     = ST_SCAN;
                        end
                        default: begin
                            n_act = ACT_OTHER;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue the next slot read
                if (issue_now) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_issue[SLOT_W-1:0];
                    n_issue     = r_issue + CNT_W'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_issue[SLOT_W-1:0];
                end
                // evaluate the slot read in the previous cycle
                if (r_cmp_valid) begin
                    case (r_kind)
                        KIND_REPORT: begin
                            if (!r_match_hit && r_used[r_cmp_idx] &&
                                (beat_ent.addr == r_addr)) begin
                                n_match_hit = 1'b1;
                                n_match_idx = r_cmp_idx;
                            end
                            // oldest entry, first expired one past slot 0 wins
                            if (r_cmp_idx == '0) begin
                                n_best_idx = '0;
                                n_tmin     = beat_ent.stamp;
                            end else if (!r_stop) begin
                                if (beat_ent.stamp < r_tmin) begin
                                    n_best_idx = r_cmp_idx;
                                    n_tmin     = beat_ent.stamp;
                                end
                                if (beat_exp) begin
                                    n_best_idx = r_cmp_idx;
                                    n_stop     = 1'b1;
                                end
                            end
                        end
                        KIND_SWEEP: begin
                            if (r_used[r_cmp_idx] &&
                                (addr_blocked(beat_ent.addr, r_blocked[0],
                                              r_blocked[1], r_blocked[2]) ||
                                 beat_exp)) begin
                                n_used[r_cmp_idx] = 1'b0;
                            end
                        end
                        KIND_READ: begin
                            n_ent = r_rd_ok ? beat_ent : '0;
                        end
                        default: begin
                            n_ent = '0;
                        end
                    endcase
                    if (!issue_now) begin
                        n_state = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                if (fin_go) begin
                    n_o_action = r_act;
                    n_o_slot   = r_slot;
                    n_o_ent    = r_ent;
                    // store the report in the chosen slot
                    if (r_store) begin
                        wr_en      = 1'b1;
                        wr_ent     = '{addr: r_addr, stamp: r_rtime, payload: r_payload};
                        if (r_match_hit) begin
                            wr_idx     = r_match_idx;
                            n_o_action = ACT_UPDATED;
                        end else if (free_any) begin
                            wr_idx     = free_idx;
                            n_o_action = ACT_INSERTED;
                        end else begin
                            wr_idx     = r_best_idx;
                            n_o_action = ACT_REPLACED;
                        end
                        n_used[wr_idx] = 1'b1;
                        n_o_slot       = OSLOT_W'(wr_idx);
                        n_o_ent        = wr_ent;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // occupied count after the item
        used_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            used_cnt = used_cnt + CNT_W'(n_used[i]);
        end
        if (fin_go) begin
            n_o_count = OCNT_W'(used_cnt);
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_ent;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_blocked[0] <= '0;
            r_blocked[1] <= '0;
            r_blocked[2] <= '0;
            r_own       <= '0;
            r_expiry    <= EXPIRY_RESET;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
            // configuration write transaction
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_BLOCKED_A: r_blocked[0] <= i_cfg.data;
                    REG_BLOCKED_B: r_blocked[1] <= i_cfg.data;
                    REG_BLOCKED_C: r_blocked[2] <= i_cfg.data;
                    REG_OWN:       r_own        <= i_cfg.data;
                    REG_EXPIRY:    r_expiry     <= i_cfg.data[EXPIRY_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_store     <= n_store;
        r_addr      <= n_addr;
        r_rtime     <= n_rtime;
        r_payload   <= n_payload;
        r_now       <= n_now;
        r_act       <= n_act;
        r_slot      <= n_slot;
        r_ent       <= n_ent;
        r_rd_ok     <= n_rd_ok;
        r_issue     <= n_issue;
        r_cmp_idx   <= n_cmp_idx;
        r_match_hit <= n_match_hit;
        r_match_idx <= n_match_idx;
        r_best_idx  <= n_best_idx;
        r_tmin      <= n_tmin;
        r_stop      <= n_stop;
        r_o_action  <= n_o_action;
        r_o_slot    <= n_o_slot;
        r_o_ent     <= n_o_ent;
        r_o_count   <= n_o_count;
    end

    // result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_o_action;
    assign o_out.slot_used      = r_o_slot;
    assign o_out.entry_address  = r_o_ent.addr;
    assign o_out.entry_time     = r_o_ent.stamp;
    assign o_out.entry_payload  = r_o_ent.payload;
    assign o_out.occupied_count = r_o_count;

endmodule

`default_nettype wire
